// ===== rtl/core/integer_to_ascii_formatter_assert.svh =====
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("itoa_fmt: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("itoa_fmt: next-cycle check failed");

`endif

// ===== rtl/core/itoa_fmt_pkg.sv =====
// Shared constants and the digit-to-ASCII function of the integer formatter.
package itoa_fmt_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic OP_DEC = 1'b0;
	localparam logic OP_HEX = 1'b1;

	// "0123456789ABCDEF"
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_UPPER + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter top level: bit-serial decimal/hex text generator.
//
// Takes one VALUE_WIDTH-bit word and a format bit per transfer and returns its
// ASCII text one character per output transfer, most significant character
// first, with last high on the final character. operation = 0 prints signed
// decimal ('-' for negative values, no leading zeros, "0" for zero; the most
// negative value prints its true magnitude). operation = 1 prints "0x",
// uppercase hex digits without leading zeros, then one space. One word is in
// flight at a time. A decimal word first passes a bit-serial double-dabble
// converter (one input bit shifted into a BCD register per cycle), then the
// leading zero digits are dropped from the digit register, then the
// characters go out while the sink takes them. Hex skips the converter. A new
// word is taken as soon as the previous word's last character sits in the
// output register, even if that character has not been taken yet.
module integer_to_ascii_formatter #(
	parameter int VALUE_WIDTH = itoa_fmt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   value_valid,
	output logic                   value_ready,
	input  logic                   operation,
	input  logic [VALUE_WIDTH-1:0] value,
	// output channel
	output logic                   character_valid,
	input  logic                   character_ready,
	output logic [7:0]             character,
	output logic                   last
);

	// Digits needed for 2**W - 1 in decimal (log10(2) ~ 0.30103) and in hex.
	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DW         = NDIG * 4;
	localparam int RW         = $clog2(NDIG + 1);
	localparam int CW         = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_HEAD,
		ST_DIGITS,
		ST_TRAIL
	} state_t;

	state_t                 state_q;
	logic                   hex_q;     // format of the word in flight
	logic                   neg_q;     // decimal word was negative
	logic                   pre_q;     // second prefix char ('x') pending
	logic [VALUE_WIDTH-1:0] bin_q;     // magnitude, shifted out MSB first
	logic [DW-1:0]          dig_q;     // digit register, top digit at MSBs
	logic [CW-1:0]          cnt_q;     // conversion bits left
	logic [RW-1:0]          rem_q;     // digits left in dig_q
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;

	logic                   take;
	logic                   out_free;
	logic                   load_out;  // a new character enters the output register
	logic                   is_neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic [DW-1:0]          dabble;
	logic [3:0]             top_dig;

	assign value_ready     = (state_q == ST_IDLE);
	assign take            = value_valid && value_ready;
	assign out_free        = !out_valid_q || character_ready;
	assign load_out        = out_free && (state_q == ST_HEAD || state_q == ST_DIGITS ||
	                                      state_q == ST_TRAIL);
	assign character_valid = out_valid_q;
	assign character       = out_char_q;
	assign last            = out_last_q;

	// Decimal reads the word as two's complement; the unsigned W-bit negation
	// of the most negative value is its true magnitude.
	assign is_neg  = (operation == itoa_fmt_pkg::OP_DEC) && value[VALUE_WIDTH-1];
	assign mag     = is_neg ? VALUE_WIDTH'(~value + 1'b1) : value;
	assign top_dig = dig_q[DW-1 -: 4];

	// Double-dabble: add 3 to every BCD digit of 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			dabble[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
			                                             : dig_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hex_q       <= 1'b0;
			neg_q       <= 1'b0;
			pre_q       <= 1'b0;
			bin_q       <= '0;
			dig_q       <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drained with nothing new behind it
			if (out_valid_q && character_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						hex_q <= (operation == itoa_fmt_pkg::OP_HEX);
						neg_q <= is_neg;
						pre_q <= 1'b0;
						bin_q <= mag;
						cnt_q <= CW'(VALUE_WIDTH);
						rem_q <= RW'(NDIG);
						if (operation == itoa_fmt_pkg::OP_HEX) begin
							// hex digits are the word's nibbles as they stand
							dig_q   <= DW'(value);
							state_q <= ST_SKIP;
						end else begin
							dig_q   <= '0;
							state_q <= ST_CONV;
						end
					end
				end

				ST_CONV: begin
					dig_q <= {dabble[DW-2:0], bin_q[VALUE_WIDTH-1]};
					bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SKIP;
					end
				end

				ST_SKIP: begin
					// drop leading zeros, always keep the units digit
					if (top_dig == 4'd0 && rem_q != RW'(1)) begin
						dig_q <= {dig_q[DW-5:0], 4'd0};
						rem_q <= rem_q - 1'b1;
					end else if (hex_q || neg_q) begin
						state_q <= ST_HEAD;
					end else begin
						state_q <= ST_DIGITS;
					end
				end

				ST_HEAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						if (!hex_q) begin
							out_char_q <= itoa_fmt_pkg::CHAR_MINUS;
							state_q    <= ST_DIGITS;
						end else if (!pre_q) begin
							out_char_q <= itoa_fmt_pkg::CHAR_ZERO;
							pre_q      <= 1'b1;
						end else begin
							out_char_q <= itoa_fmt_pkg::CHAR_X;
							state_q    <= ST_DIGITS;
						end
					end
				end

				ST_DIGITS: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= itoa_fmt_pkg::digit_char(top_dig);
						out_last_q  <= (rem_q == RW'(1)) && !hex_q;
						dig_q       <= {dig_q[DW-5:0], 4'd0};
						rem_q       <= rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= hex_q ? ST_TRAIL : ST_IDLE;
						end
					end
				end

				ST_TRAIL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= itoa_fmt_pkg::CHAR_SPACE;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "integer_to_ascii_formatter_assert.svh"

	// a decimal word always goes through the converter first
	`ITOA_ASSERT_NEXT(a_dec_to_conv, clk, arst_n, take && (operation == itoa_fmt_pkg::OP_DEC), state_q == ST_CONV)
	// the converter never runs with no bits left
	`ITOA_ASSERT_SAME(a_conv_count, clk, arst_n, state_q == ST_CONV, cnt_q != '0)
	// zero skipping and emission never run past the units digit
	`ITOA_ASSERT_SAME(a_digits_left, clk, arst_n, state_q == ST_SKIP || state_q == ST_DIGITS, rem_q != '0)

endmodule
